// ===== src/gqi_pkg.sv =====
// shared types and constants for the gyro quaternion integrator
package gqi_pkg;

  localparam int QUAT_FRAC_BITS_DEF = 30;

  // configuration register indexes
  localparam logic [2:0] REG_BIAS_X    = 3'd0;
  localparam logic [2:0] REG_BIAS_Y    = 3'd1;
  localparam logic [2:0] REG_BIAS_Z    = 3'd2;
  localparam logic [2:0] REG_DEAD_ZONE = 3'd3;
  localparam logic [2:0] REG_GAIN      = 3'd4;

  localparam logic [15:0] DEAD_ZONE_RST = 16'd5;
  localparam logic [31:0] GAIN_RST      = 32'd149780;

  localparam logic OP_INTEGRATE = 1'b0;
  localparam logic OP_IDENTITY  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_SCALE,
    ST_SQR,
    ST_SQRT,
    ST_DIV,
    ST_OUT
  } gqi_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input beat
    logic set_ident; // force identity
    logic prod_step; // one cross-product term
    logic scl_step;  // one gain scaling step
    logic sqr_step;  // one square accumulate
    logic sqrt_init;
    logic sqrt_step;
    logic div_init;
    logic div_step;
    logic commit;    // write normalized quaternion
  } gqi_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic prod_done;
    logic scl_done;
    logic sqr_done;
    logic sqrt_done;
    logic root_zero;
    logic div_done;
    logic is_ident;
  } gqi_sts_t;

endpackage

// ===== src/gqi_ctrl.sv =====
// controller sequencing one integration step over the shared datapath
module gqi_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output gqi_pkg::gqi_cmd_t cmd,
  input  gqi_pkg::gqi_sts_t sts
);

  gqi_pkg::gqi_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= gqi_pkg::ST_IDLE;
    else state <= state_next;
  end

  // output beat pending while a finished result waits
  logic pend, pend_next;
  always_ff @(posedge clk) begin
    if (rst) pend <= 1'b0;
    else pend <= pend_next;
  end

  assign out_valid = pend;
  assign in_stall  = (state != gqi_pkg::ST_IDLE) || (pend && out_stall);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    pend_next = pend && out_stall;
    unique case (state)
      gqi_pkg::ST_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.load = 1'b1;
          state_next = gqi_pkg::ST_PROD;
        end
      end
      gqi_pkg::ST_PROD: begin
        if (sts.is_ident) begin
          cmd.set_ident = 1'b1;
          state_next = gqi_pkg::ST_OUT;
        end else begin
          cmd.prod_step = 1'b1;
          if (sts.prod_done) state_next = gqi_pkg::ST_SCALE;
        end
      end
      gqi_pkg::ST_SCALE: begin
        cmd.scl_step = 1'b1;
        if (sts.scl_done) state_next = gqi_pkg::ST_SQR;
      end
      gqi_pkg::ST_SQR: begin
        cmd.sqr_step = 1'b1;
        if (sts.sqr_done) begin
          cmd.sqrt_init = 1'b1;
          state_next = gqi_pkg::ST_SQRT;
        end
      end
      gqi_pkg::ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.sqrt_done) begin
          if (sts.root_zero) begin
            cmd.set_ident = 1'b1;
            state_next = gqi_pkg::ST_OUT;
          end else begin
            cmd.div_init = 1'b1;
            state_next = gqi_pkg::ST_DIV;
          end
        end
      end
      gqi_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          cmd.commit = 1'b1;
          state_next = gqi_pkg::ST_OUT;
        end
      end
      gqi_pkg::ST_OUT: begin
        pend_next = 1'b1;
        state_next = gqi_pkg::ST_IDLE;
      end
      default: state_next = gqi_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== src/gqi_datapath.sv =====
// datapath: shared multiplier, gain scaler, square root and divider
module gqi_datapath #(
  parameter int QUAT_FRAC_BITS = gqi_pkg::QUAT_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  gqi_pkg::gqi_cmd_t        cmd,
  output gqi_pkg::gqi_sts_t        sts,
  input  logic                     opcode,
  input  logic signed [15:0]       rate_x,
  input  logic signed [15:0]       rate_y,
  input  logic signed [15:0]       rate_z,
  input  logic [2:0]               cfg_index,
  input  logic [31:0]              cfg_data,
  input  logic                     cfg_we,
  output logic signed [31:0]       quat_w,
  output logic signed [31:0]       quat_x,
  output logic signed [31:0]       quat_y,
  output logic signed [31:0]       quat_z
);

  localparam logic signed [31:0] ONE = 32'sd1 <<< QUAT_FRAC_BITS;
  localparam int DIVW = 32 + QUAT_FRAC_BITS;

  // configuration registers
  logic signed [15:0] bias_x, bias_y, bias_z;
  logic [15:0] dead_zone;
  logic [31:0] gain;
  always_ff @(posedge clk) begin
    if (rst) begin
      bias_x <= '0;
      bias_y <= '0;
      bias_z <= '0;
      dead_zone <= gqi_pkg::DEAD_ZONE_RST;
      gain <= gqi_pkg::GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gqi_pkg::REG_BIAS_X:    bias_x <= cfg_data[15:0];
        gqi_pkg::REG_BIAS_Y:    bias_y <= cfg_data[15:0];
        gqi_pkg::REG_BIAS_Z:    bias_z <= cfg_data[15:0];
        gqi_pkg::REG_DEAD_ZONE: dead_zone <= cfg_data[15:0];
        gqi_pkg::REG_GAIN:      gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // attitude state
  logic signed [31:0] q [4];
  logic ident;

  // bias and dead zone
  function automatic logic signed [16:0] dz(input logic signed [15:0] r,
                                            input logic signed [15:0] b,
                                            input logic [15:0] d);
    logic signed [16:0] c;
    logic [16:0] m;
    c = 17'(r) - 17'(b);
    m = c[16] ? 17'(-c) : 17'(c);
    dz = (m < {1'b0, d}) ? 17'sd0 : c;
  endfunction

  logic signed [16:0] g [3];

  // product sequencer: 12 terms, one multiply per cycle
  logic [3:0] pcnt;
  logic signed [51:0] s [4];
  logic signed [31:0] pa;
  logic signed [16:0] pb;
  logic pneg;
  logic [1:0] pdst;
  always_comb begin
    pa = q[0]; pb = g[0]; pneg = 1'b0; pdst = 2'd0;
    case (pcnt)
      4'd0:  begin pa = q[1]; pb = g[0]; pneg = 1'b1; pdst = 2'd0; end
      4'd1:  begin pa = q[2]; pb = g[1]; pneg = 1'b1; pdst = 2'd0; end
      4'd2:  begin pa = q[3]; pb = g[2]; pneg = 1'b1; pdst = 2'd0; end
      4'd3:  begin pa = q[0]; pb = g[0]; pneg = 1'b0; pdst = 2'd1; end
      4'd4:  begin pa = q[2]; pb = g[2]; pneg = 1'b0; pdst = 2'd1; end
      4'd5:  begin pa = q[3]; pb = g[1]; pneg = 1'b1; pdst = 2'd1; end
      4'd6:  begin pa = q[0]; pb = g[1]; pneg = 1'b0; pdst = 2'd2; end
      4'd7:  begin pa = q[1]; pb = g[2]; pneg = 1'b1; pdst = 2'd2; end
      4'd8:  begin pa = q[3]; pb = g[0]; pneg = 1'b0; pdst = 2'd2; end
      4'd9:  begin pa = q[0]; pb = g[2]; pneg = 1'b0; pdst = 2'd3; end
      4'd10: begin pa = q[1]; pb = g[1]; pneg = 1'b0; pdst = 2'd3; end
      4'd11: begin pa = q[2]; pb = g[0]; pneg = 1'b1; pdst = 2'd3; end
      default: ;
    endcase
  end
  logic signed [48:0] prod;
  assign prod = 49'(pa) * 49'(pb);

  // gain scaler: low 24 bits and high 28 bits of each component in turn
  logic [2:0] scnt;
  logic [51:0] smag;
  logic [56:0] slo;
  logic [63:0] st;
  logic signed [33:0] qn [4];
  logic signed [33:0] qsum;
  logic [1:0] sidx;
  assign sidx = scnt[2:1];
  assign smag = s[sidx][51] ? 52'(-s[sidx]) : 52'(s[sidx]);
  assign st = 64'(smag[51:24]) * 64'(gain) + 64'(slo >> 24) + 64'h80_0000;
  assign qsum = 34'(q[sidx]) + (s[sidx][51] ? -34'(st >> 24) : 34'(st >> 24));

  // square accumulate
  logic [2:0] qcnt;
  logic [63:0] sumsq;
  logic signed [31:0] sq_in;
  logic [31:0] sq_mag;
  logic [63:0] sq_prod;
  assign sq_in = qn[qcnt[1:0]][31:0];
  assign sq_mag = sq_in[31] ? 32'(-sq_in) : 32'(sq_in);
  assign sq_prod = 64'(sq_mag) * 64'(sq_mag);

  // restoring square root, one result bit per cycle
  logic [5:0] rcnt;
  logic [63:0] rrem, rres, rbit;
  logic [63:0] rres_next;
  logic [31:0] root;
  assign rres_next = (rrem >= rres + rbit) ? (rres >> 1) + rbit : rres >> 1;

  // restoring divider, one quotient bit per cycle, one component at a time
  logic [1:0] didx;
  logic [6:0] dcnt;
  logic [DIVW-1:0] dnum, dquo;
  logic [32:0] drem;
  logic [31:0] dmag;
  logic signed [31:0] nq [4];
  logic [33:0] dtry;
  assign dmag = qn[didx][31] ? 32'(-qn[didx][31:0]) : qn[didx][31:0];
  assign dtry = {drem, dnum[DIVW-1]} - {2'b00, root};

  always_ff @(posedge clk) begin
    if (rst) begin
      q[0] <= ONE; q[1] <= '0; q[2] <= '0; q[3] <= '0;
      pcnt <= '0; scnt <= '0; qcnt <= '0; rcnt <= '0; didx <= '0; dcnt <= '0;
    end else begin
      if (cmd.load) begin
        ident <= (opcode == gqi_pkg::OP_IDENTITY);
        g[0] <= dz(rate_x, bias_x, dead_zone);
        g[1] <= dz(rate_y, bias_y, dead_zone);
        g[2] <= dz(rate_z, bias_z, dead_zone);
        for (int i = 0; i < 4; i++) s[i] <= '0;
        pcnt <= '0; scnt <= '0; qcnt <= '0; sumsq <= '0;
      end
      if (cmd.prod_step) begin
        s[pdst] <= pneg ? s[pdst] - 52'(prod) : s[pdst] + 52'(prod);
        pcnt <= pcnt + 4'd1;
      end
      // even step: low product, odd step: high product and final add
      if (cmd.scl_step) begin
        if (!scnt[0]) begin
          slo <= 57'({32'd0, smag[23:0]}) * 57'(gain);
        end else begin
          if (qsum > 34'sd2147483647) qn[sidx] <= 34'sd2147483647;
          else if (qsum < -34'sd2147483647) qn[sidx] <= -34'sd2147483647;
          else qn[sidx] <= qsum;
        end
        scnt <= scnt + 3'd1;
      end
      if (cmd.sqr_step) begin
        sumsq <= sumsq + sq_prod;
        qcnt <= qcnt + 3'd1;
      end
      // init comes with the last square, which is folded in here
      if (cmd.sqrt_init) begin
        rrem <= sumsq + sq_prod; rres <= '0; rbit <= 64'd1 << 62; rcnt <= '0;
      end else if (cmd.sqrt_step) begin
        if (rrem >= rres + rbit) begin
          rrem <= rrem - (rres + rbit);
        end
        rres <= rres_next;
        rbit <= rbit >> 2;
        rcnt <= rcnt + 6'd1;
      end
      if (cmd.div_init) begin
        root <= rres_next[31:0];
        didx <= '0; dcnt <= '0;
      end
      if (cmd.div_step) begin
        if (dcnt == 7'd0) begin
          // numerator is magnitude scaled up plus half the divisor
          dnum <= DIVW'({dmag, QUAT_FRAC_BITS'(0)}) + DIVW'(root >> 1);
          drem <= '0; dquo <= '0;
          dcnt <= 7'd1;
        end else begin
          if (!dtry[33]) begin
            drem <= dtry[32:0];
            dquo <= {dquo[DIVW-2:0], 1'b1};
          end else begin
            drem <= {drem[31:0], dnum[DIVW-1]};
            dquo <= {dquo[DIVW-2:0], 1'b0};
          end
          dnum <= {dnum[DIVW-2:0], 1'b0};
          if (dcnt == 7'(DIVW + 1)) begin
            dcnt <= '0;
            didx <= didx + 2'd1;
          end else begin
            dcnt <= dcnt + 7'd1;
          end
        end
        if (dcnt == 7'(DIVW + 1)) begin
          nq[didx] <= qn[didx][31] ? -32'(dquo) : 32'(dquo);
        end
      end
      if (cmd.commit) begin
        q[0] <= nq[0]; q[1] <= nq[1]; q[2] <= nq[2];
        q[3] <= qn[3][31] ? -32'(dquo) : 32'(dquo);
      end
      if (cmd.set_ident) begin
        q[0] <= ONE; q[1] <= '0; q[2] <= '0; q[3] <= '0;
      end
    end
  end

  // status
  assign sts.is_ident  = ident;
  assign sts.prod_done = (pcnt == 4'd11);
  assign sts.scl_done  = (scnt == 3'd7);
  assign sts.sqr_done  = (qcnt == 3'd3);
  assign sts.sqrt_done = (rcnt == 6'd31);
  assign sts.root_zero = (rres_next == 64'd0);
  assign sts.div_done  = (didx == 2'd3) && (dcnt == 7'(DIVW + 1));

  assign quat_w = q[0];
  assign quat_x = q[1];
  assign quat_y = q[2];
  assign quat_z = q[3];

endmodule

// ===== src/gyro_quaternion_integrator_top.sv =====
// top level of the gyro quaternion integrator
//
// One input beat carries opcode and three raw gyro rates. Opcode integrate
// removes bias, applies the dead zone, scales by the half step gain, takes
// a first-order quaternion step and renormalizes (identity on a zero norm);
// opcode identity resets the attitude. Each input beat yields exactly one
// output beat with the four Q2.30 quaternion components.
// After the accepting edge the step runs, in order: the cross-product terms
// on one multiplier, the gain scaling, the squaring, the square root, four
// serial divisions that give the Q2.30 components and the output state, after
// which out_valid rises. The next beat can be accepted at the edge the result
// is taken. An identity beat skips the arithmetic and passes only through the
// product and output states. One item is in flight at a time; in_stall is high
// while the step runs and while a result is held because out_stall is high.
// Synchronous reset sets the identity quaternion and the register reset
// values. Configuration is to be written over cfg_valid/cfg_ready only while
// the block is idle; it does not enforce this. cfg_ready is always high.
module gyro_quaternion_integrator_top #(
  parameter int QUAT_FRAC_BITS = gqi_pkg::QUAT_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               opcode,
  input  logic signed [15:0] rate_x,
  input  logic signed [15:0] rate_y,
  input  logic signed [15:0] rate_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] quat_w,
  output logic signed [31:0] quat_x,
  output logic signed [31:0] quat_y,
  output logic signed [31:0] quat_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  gqi_pkg::gqi_cmd_t cmd;
  gqi_pkg::gqi_sts_t sts;

  assign cfg_ready = 1'b1;

  gqi_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .cmd(cmd), .sts(sts)
  );

  gqi_datapath #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .opcode(opcode), .rate_x(rate_x), .rate_y(rate_y), .rate_z(rate_z),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .cfg_we(cfg_valid && cfg_ready),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z)
  );

`ifndef SYNTH
  // no new beat accepted while a result waits stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> in_stall)
    else $error("input accepted over pending result");
  // held result stays valid, with quat_w and quat_z stable
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(quat_w) && $stable(quat_z)))
    else $error("pending result changed");
  // accepted beat makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block not busy after accept");
`endif

endmodule

// ===== verif/tb.sv =====
// self-checking testbench for the gyro quaternion integrator top level
module tb;

  localparam int FRAC = gqi_pkg::QUAT_FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_CYCLES = 400;

  typedef struct {
    logic              op;
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    logic signed [15:0] rz;
  } gyro_beat_t;

  typedef struct {
    logic signed [31:0] w;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } quat_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               opcode = gqi_pkg::OP_INTEGRATE;
  logic signed [15:0] rate_x = '0;
  logic signed [15:0] rate_y = '0;
  logic signed [15:0] rate_z = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] quat_w, quat_x, quat_y, quat_z;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = gqi_pkg::REG_BIAS_X;
  logic [31:0]        cfg_data = '0;

  gyro_quaternion_integrator_top dut (.*);

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state and configuration copy
  longint             cfg_bias_x = 0, cfg_bias_y = 0, cfg_bias_z = 0;
  longint             cfg_dead_zone = gqi_pkg::DEAD_ZONE_RST;
  logic [31:0]        cfg_gain = gqi_pkg::GAIN_RST;
  logic signed [31:0] attitude [4] = '{32'sd1 << FRAC, 0, 0, 0};

  gyro_beat_t pending_beats [$];
  quat_t      expected_quats [$];
  int         error_count = 0;
  int         send_idle_pct = 14;
  int         recv_idle_pct = 79;
  logic       hold_req = 1'b0;
  logic       hold_seen = 1'b0;
  int         hold_left = 0;
  int         cycle_count = 0;

  function automatic longint apply_dead_zone(longint c);
    longint mag;
    mag = (c < 0) ? -c : c;
    return (mag < cfg_dead_zone) ? 0 : c;
  endfunction

  // round(s * gain / 2^48), half away from zero
  function automatic longint gain_scale(longint s);
    logic [127:0] mag;
    logic [127:0] prod;
    longint       r;
    mag = (s < 0) ? 128'(-s) : 128'(s);
    prod = mag * 128'(cfg_gain) + (128'd1 << 47);
    r = longint'(prod >> 48);
    return (s < 0) ? -r : r;
  endfunction

  function automatic longint clamp31(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483647) return -64'sd2147483647;
    return v;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] rem, res, b;
    rem = v;
    res = 0;
    b = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic void set_identity();
    attitude[0] = 32'sd1 << FRAC;
    attitude[1] = 0;
    attitude[2] = 0;
    attitude[3] = 0;
  endfunction

  // advance the attitude by one beat and return the new quaternion
  function automatic quat_t advance_attitude(gyro_beat_t b);
    longint      gx, gy, gz, w, x, y, z;
    longint      s [4];
    longint      q [4];
    logic [63:0] sum, n, mag, r;
    quat_t       res;
    if (b.op == gqi_pkg::OP_IDENTITY) begin
      set_identity();
    end else begin
      gx = apply_dead_zone(longint'(b.rx) - cfg_bias_x);
      gy = apply_dead_zone(longint'(b.ry) - cfg_bias_y);
      gz = apply_dead_zone(longint'(b.rz) - cfg_bias_z);
      w = attitude[0];
      x = attitude[1];
      y = attitude[2];
      z = attitude[3];
      s[0] = -x * gx - y * gy - z * gz;
      s[1] = w * gx + y * gz - z * gy;
      s[2] = w * gy - x * gz + z * gx;
      s[3] = w * gz + x * gy - y * gx;
      sum = 0;
      for (int i = 0; i < 4; i++) begin
        q[i] = clamp31(longint'(attitude[i]) + gain_scale(s[i]));
        sum = sum + 64'(q[i] * q[i]);
      end
      n = int_sqrt(sum);
      if (n == 0) begin
        set_identity();
      end else begin
        for (int i = 0; i < 4; i++) begin
          mag = (q[i] < 0) ? 64'(-q[i]) : 64'(q[i]);
          r = ((mag << FRAC) + (n >> 1)) / n;
          attitude[i] = (q[i] < 0) ? -32'(r) : 32'(r);
        end
      end
    end
    res.w = attitude[0];
    res.x = attitude[1];
    res.y = attitude[2];
    res.z = attitude[3];
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", field,
             $signed(got), $signed(want), cycle_count);
    error_count++;
  endtask

  // input driver: predicts each beat as it is accepted
  always @(posedge clk) begin
    gyro_beat_t nb;
    gyro_beat_t cur;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        cur.op = opcode;
        cur.rx = rate_x;
        cur.ry = rate_y;
        cur.rz = rate_z;
        expected_quats.push_back(advance_attitude(cur));
      end
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nb = pending_beats.pop_front();
        opcode <= nb.op;
        rate_x <= nb.rx;
        rate_y <= nb.ry;
        rate_z <= nb.rz;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stall, with a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 3000;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    quat_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_quats.size() == 0) begin
        $display("unexpected result beat at cycle %0d", cycle_count);
        error_count++;
      end else begin
        e = expected_quats.pop_front();
        if (quat_w !== e.w) report_mismatch("quat_w", quat_w, e.w);
        if (quat_x !== e.x) report_mismatch("quat_x", quat_x, e.x);
        if (quat_y !== e.y) report_mismatch("quat_y", quat_y, e.y);
        if (quat_z !== e.z) report_mismatch("quat_z", quat_z, e.z);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      gqi_pkg::REG_BIAS_X:    cfg_bias_x = longint'($signed(val[15:0]));
      gqi_pkg::REG_BIAS_Y:    cfg_bias_y = longint'($signed(val[15:0]));
      gqi_pkg::REG_BIAS_Z:    cfg_bias_z = longint'($signed(val[15:0]));
      gqi_pkg::REG_DEAD_ZONE: cfg_dead_zone = longint'(val[15:0]);
      gqi_pkg::REG_GAIN:      cfg_gain = val;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_beats.size() != 0 || in_valid || expected_quats.size() != 0);
  endtask

  task automatic push_beat(logic op, int rx, int ry, int rz);
    pending_beats.push_back('{op, 16'(rx), 16'(ry), 16'(rz)});
  endtask

  // rate near the bias and dead-zone edges, at the extremes, or anywhere
  function automatic int pick_rate(longint bias);
    case ($urandom_range(3))
      0: return int'(bias) + $urandom_range(40) - 20;
      1: return $urandom_range(1) ? 32767 : -32768;
      default: return int'($urandom_range(16'hffff));
    endcase
  endfunction

  // stimulus
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: default registers
    push_beat(gqi_pkg::OP_IDENTITY, 1234, -999, 7);
    push_beat(gqi_pkg::OP_INTEGRATE, 0, 0, 0);
    push_beat(gqi_pkg::OP_INTEGRATE, 4, -4, 4);
    push_beat(gqi_pkg::OP_INTEGRATE, 5, -5, 5);
    push_beat(gqi_pkg::OP_INTEGRATE, 32767, 0, 0);
    push_beat(gqi_pkg::OP_INTEGRATE, 0, -32768, 0);
    push_beat(gqi_pkg::OP_INTEGRATE, 0, 0, 32767);
    push_beat(gqi_pkg::OP_INTEGRATE, -32768, -32768, -32768);
    push_beat(gqi_pkg::OP_INTEGRATE, 32767, 32767, 32767);
    push_beat(gqi_pkg::OP_IDENTITY, -32768, 32767, -1);
    push_beat(gqi_pkg::OP_INTEGRATE, -1, 1, -6);
    hold_req = 1'b1;
    wait_drained();

    // directed: extreme gain saturates the step, extreme biases and dead zone
    write_reg(gqi_pkg::REG_GAIN, 32'hffffffff);
    write_reg(gqi_pkg::REG_DEAD_ZONE, 16'd0);
    push_beat(gqi_pkg::OP_INTEGRATE, 32767, -32768, 32767);
    push_beat(gqi_pkg::OP_INTEGRATE, -32768, 32767, 100);
    push_beat(gqi_pkg::OP_INTEGRATE, 1, 0, 0);
    push_beat(gqi_pkg::OP_IDENTITY, 0, 0, 0);
    wait_drained();
    write_reg(gqi_pkg::REG_BIAS_X, 32'h00008000);
    write_reg(gqi_pkg::REG_BIAS_Y, 32'h00007fff);
    write_reg(gqi_pkg::REG_BIAS_Z, 32'h0000ffff);
    write_reg(gqi_pkg::REG_DEAD_ZONE, 16'hffff);
    push_beat(gqi_pkg::OP_INTEGRATE, 32767, -32768, 0);
    push_beat(gqi_pkg::OP_INTEGRATE, -32768, 32767, 32767);
    push_beat(gqi_pkg::OP_INTEGRATE, 0, 0, 0);
    wait_drained();

    // random phases, each with its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 2) begin
        send_idle_pct = 14;
        recv_idle_pct = 79;
      end else if (ph < 4) begin
        send_idle_pct = 79;
        recv_idle_pct = 14;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        0: begin
          write_reg(gqi_pkg::REG_BIAS_X, 32'd0);
          write_reg(gqi_pkg::REG_BIAS_Y, 32'd0);
          write_reg(gqi_pkg::REG_BIAS_Z, 32'd0);
          write_reg(gqi_pkg::REG_DEAD_ZONE, gqi_pkg::DEAD_ZONE_RST);
          write_reg(gqi_pkg::REG_GAIN, gqi_pkg::GAIN_RST);
        end
        1: write_reg(gqi_pkg::REG_GAIN, 32'd0);
        2: write_reg(gqi_pkg::REG_GAIN, 32'hffffffff);
        default: begin
          write_reg(gqi_pkg::REG_BIAS_X, $urandom);
          write_reg(gqi_pkg::REG_BIAS_Y, $urandom);
          write_reg(gqi_pkg::REG_BIAS_Z, $urandom);
          write_reg(gqi_pkg::REG_DEAD_ZONE, $urandom_range(200));
          write_reg(gqi_pkg::REG_GAIN,
                    $urandom_range(1) ? $urandom : $urandom_range(2000000));
        end
      endcase
      for (int i = 0; i < 135; i++) begin
        push_beat(($urandom_range(9) == 0) ? gqi_pkg::OP_IDENTITY : gqi_pkg::OP_INTEGRATE,
                  pick_rate(cfg_bias_x), pick_rate(cfg_bias_y), pick_rate(cfg_bias_z));
        // sender pause until everything is back
        if (i == 70) wait_drained();
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== gyro_quaternion_integrator_top.f =====
src/gqi_pkg.sv
src/gqi_ctrl.sv
src/gqi_datapath.sv
src/gyro_quaternion_integrator_top.sv
verif/tb.sv
